[src/idbw_pkg.sv]
// Shared types and constants for the I2C display byte writer.
// Used by every module of the block; depends on nothing else.
package idbw_pkg;

    // Bus address and control byte widths.
    localparam int ADDR_W = 7;
    localparam int BYTE_W = 8;

    // Address after reset: 0x3C, which gives an address byte of 0x78.
    localparam logic [ADDR_W-1:0] ADDR_RESET = 7'd60;

    // Control bytes that select a command or display RAM data.
    localparam logic [BYTE_W-1:0] CTRL_CMD  = 8'h00;
    localparam logic [BYTE_W-1:0] CTRL_DATA = 8'h40;

    // Selector codes on the func input.
    localparam logic FUNC_CMD  = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    // Default depth of the queue between the front and back parts.
    localparam int FIFO_DEPTH = 2;

    // Each transaction sends three bytes; counting starts at zero.
    localparam logic [1:0] LAST_BYTE = 2'd2;
    localparam logic [2:0] LAST_BIT  = 3'd7;

    // Kind of bus symbol on the result ports.
    typedef enum logic [1:0] {
        SYM_START = 2'd0,
        SYM_BIT   = 2'd1,
        SYM_ACK   = 2'd2,
        SYM_STOP  = 2'd3
    } t_symbol_kind;

    // One classified transaction: the three bytes sent MSB first.
    typedef struct packed {
        logic [BYTE_W-1:0] addr_byte;
        logic [BYTE_W-1:0] ctrl_byte;
        logic [BYTE_W-1:0] payload;
    } t_entry;

    // Sequencer states of the back part.
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_START,
        SEQ_BITS,
        SEQ_ACK,
        SEQ_STOP
    } t_seq_state;

endpackage

[src/idbw_front.sv]
// Front part: holds the address register, accepts input transactions and
// turns each into the three bytes of an I2C write. Depends on idbw_pkg.
module idbw_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [idbw_pkg::BYTE_W-1:0]  i_payload,
    input  logic                         i_func,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [idbw_pkg::ADDR_W-1:0]  i_cfg_data,
    output logic                         o_wr_valid,
    output idbw_pkg::t_entry             o_wr_entry,
    input  logic                         i_wr_ready
);

    logic [idbw_pkg::ADDR_W-1:0] r_addr;
    logic                        r_valid;
    logic                        n_valid;
    idbw_pkg::t_entry            r_entry;
    idbw_pkg::t_entry            n_entry;
    logic                        accept;

    // The address register takes every write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= idbw_pkg::ADDR_RESET;
        end else if (i_cfg_valid) begin
            r_addr <= i_cfg_data;
        end
    end

    // The holding stage is free when empty or when its entry moves on.
    assign o_full = r_valid && !i_wr_ready;
    assign accept = i_push && !o_full;

    // Classify the transaction: address byte with write bit, control byte.
    always_comb begin
        n_entry.addr_byte = {r_addr, 1'b0};
        n_entry.ctrl_byte = (i_func == idbw_pkg::FUNC_DATA) ? idbw_pkg::CTRL_DATA
                                                            : idbw_pkg::CTRL_CMD;
        n_entry.payload   = i_payload;
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_wr_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

    assign o_wr_valid = r_valid;
    assign o_wr_entry = r_entry;

endmodule

[src/idbw_fifo.sv]
// Short queue of classified transactions between the front and back parts.
// Depends on idbw_pkg for the entry type.
module idbw_fifo #(
    parameter int DEPTH = idbw_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    input  idbw_pkg::t_entry i_wr_entry,
    output logic             o_wr_ready,
    output logic             o_rd_valid,
    output idbw_pkg::t_entry o_rd_entry,
    input  logic             i_rd_en
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    idbw_pkg::t_entry  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              wr_en;
    logic              rd_en;

    assign o_wr_ready = (r_count != CNT_FULL);
    assign o_rd_valid = (r_count != '0);
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = i_rd_en && o_rd_valid;
    assign o_rd_entry = r_mem[r_rd_ptr];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[src/idbw_back.sv]
// Back part: steps through the 29 bus symbols of each transaction and holds
// the current symbol in an output register. Depends on idbw_pkg.
module idbw_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_valid,
    input  idbw_pkg::t_entry i_rd_entry,
    output logic             o_rd_en,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [1:0]       o_symbol_kind,
    output logic             o_sda_level,
    output logic             o_last_symbol
);

    idbw_pkg::t_seq_state   r_state;
    idbw_pkg::t_seq_state   n_state;
    logic [3*idbw_pkg::BYTE_W-1:0] r_shift;
    logic [2:0]             r_bit_cnt;
    logic [1:0]             r_byte_cnt;
    logic                   r_out_valid;
    idbw_pkg::t_symbol_kind r_kind;
    logic                   r_sda;
    logic                   r_last;
    logic                   adv;
    logic                   emit;
    logic                   load;
    idbw_pkg::t_symbol_kind sym_kind;
    logic                   sym_sda;
    logic                   sym_last;

    // Outside idle, the sequencer moves on whenever the output register can take a symbol.
    assign adv = !r_out_valid || i_pop;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            idbw_pkg::SEQ_IDLE: begin
                if (i_rd_valid) n_state = idbw_pkg::SEQ_START;
            end
            idbw_pkg::SEQ_START: begin
                if (adv) n_state = idbw_pkg::SEQ_BITS;
            end
            idbw_pkg::SEQ_BITS: begin
                if (adv && r_bit_cnt == idbw_pkg::LAST_BIT) n_state = idbw_pkg::SEQ_ACK;
            end
            idbw_pkg::SEQ_ACK: begin
                if (adv) begin
                    n_state = (r_byte_cnt == idbw_pkg::LAST_BYTE) ? idbw_pkg::SEQ_STOP
                                                                  : idbw_pkg::SEQ_BITS;
                end
            end
            idbw_pkg::SEQ_STOP: begin
                if (adv) begin
                    n_state = i_rd_valid ? idbw_pkg::SEQ_START : idbw_pkg::SEQ_IDLE;
                end
            end
            default: n_state = idbw_pkg::SEQ_IDLE;
        endcase
    end

    // Symbol produced in each state, and when a new transaction is loaded.
    always_comb begin
        emit     = 1'b0;
        load     = 1'b0;
        sym_kind = idbw_pkg::SYM_START;
        sym_sda  = 1'b0;
        sym_last = 1'b0;
        unique case (r_state)
            idbw_pkg::SEQ_IDLE: begin
                load = i_rd_valid;
            end
            idbw_pkg::SEQ_START: begin
                emit     = adv;
                sym_kind = idbw_pkg::SYM_START;
            end
            idbw_pkg::SEQ_BITS: begin
                emit     = adv;
                sym_kind = idbw_pkg::SYM_BIT;
                sym_sda  = r_shift[3*idbw_pkg::BYTE_W-1];
            end
            idbw_pkg::SEQ_ACK: begin
                // SDA is released during the acknowledge clock.
                emit     = adv;
                sym_kind = idbw_pkg::SYM_ACK;
                sym_sda  = 1'b1;
            end
            idbw_pkg::SEQ_STOP: begin
                emit     = adv;
                sym_kind = idbw_pkg::SYM_STOP;
                sym_last = 1'b1;
                load     = adv && i_rd_valid;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign o_rd_en = load;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= idbw_pkg::SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Bit and byte counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_cnt  <= '0;
            r_byte_cnt <= '0;
        end else if (adv) begin
            if (r_state == idbw_pkg::SEQ_START) begin
                r_bit_cnt  <= '0;
                r_byte_cnt <= '0;
            end else if (r_state == idbw_pkg::SEQ_BITS) begin
                r_bit_cnt <= r_bit_cnt + 1'b1;
            end else if (r_state == idbw_pkg::SEQ_ACK) begin
                r_byte_cnt <= r_byte_cnt + 1'b1;
            end
        end
    end

    // Shift register with the three bytes, MSB first.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_shift <= i_rd_entry;
        end else if (adv && r_state == idbw_pkg::SEQ_BITS) begin
            r_shift <= {r_shift[3*idbw_pkg::BYTE_W-2:0], 1'b0};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= sym_kind;
            r_sda  <= sym_sda;
            r_last <= sym_last;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_symbol_kind = r_kind;
    assign o_sda_level   = r_sda;
    assign o_last_symbol = r_last;

endmodule

[src/i2c_display_byte_writer.sv]
// Top level of the I2C display byte writer: front part, queue, back part.
// Depends on idbw_pkg, idbw_front, idbw_fifo and idbw_back.

// Each accepted byte becomes one I2C write transaction of 29 symbols: start,
// address byte (address shifted left, write bit 0), acknowledge, control
// byte (0x00 for a command, 0x40 for display data), acknowledge, the payload
// byte MSB first, acknowledge, stop. One symbol leaves per clock while pop is
// held and a transaction is under way in the back part. Besides the byte being
// sent, input bytes are taken up to the queue depth plus one holding stage, and
// full rises only when that space is used up. When the block has been idle, a
// pushed byte passes the holding stage, the queue and the idle and start states
// of the back part before its first symbol is registered on the result ports.
// The address register is written through the configuration channel, which is
// always ready; reset sets it to 0x3C.
module i2c_display_byte_writer #(
    parameter int FIFO_DEPTH = idbw_pkg::FIFO_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [idbw_pkg::BYTE_W-1:0] i_payload,
    input  logic                        i_func,
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  o_symbol_kind,
    output logic                        o_sda_level,
    output logic                        o_last_symbol,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [idbw_pkg::ADDR_W-1:0] i_cfg_data
);

    logic             front_valid;
    idbw_pkg::t_entry front_entry;
    logic             fifo_ready;
    logic             fifo_valid;
    idbw_pkg::t_entry fifo_entry;
    logic             back_rd_en;

    // Accept and classify transactions.
    idbw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_payload   (i_payload),
        .i_func      (i_func),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_wr_valid  (front_valid),
        .o_wr_entry  (front_entry),
        .i_wr_ready  (fifo_ready)
    );

    // Queue between the two parts.
    idbw_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .i_wr_entry (front_entry),
        .o_wr_ready (fifo_ready),
        .o_rd_valid (fifo_valid),
        .o_rd_entry (fifo_entry),
        .i_rd_en    (back_rd_en)
    );

    // Emit the bus symbols.
    idbw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_valid    (fifo_valid),
        .i_rd_entry    (fifo_entry),
        .o_rd_en       (back_rd_en),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_symbol_kind (o_symbol_kind),
        .o_sda_level   (o_sda_level),
        .o_last_symbol (o_last_symbol)
    );

endmodule
